@@ design/nwrt_pkg.sv @@
// ----------------------------------------------------------------------------
// nwrt_pkg
// Types and constants shared by the NAT wildcard rule table.
// ----------------------------------------------------------------------------
package nwrt_pkg;

   localparam int IpWidth     = 32;
   localparam int PortWidth   = 16;
   localparam int StatusWidth = 3;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic [StatusWidth-1:0] ST_STORED  = 3'd0;
   localparam logic [StatusWidth-1:0] ST_MATCH   = 3'd1;
   localparam logic [StatusWidth-1:0] ST_NOMATCH = 3'd2;
   localparam logic [StatusWidth-1:0] ST_BADWILD = 3'd3;
   localparam logic [StatusWidth-1:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic                 action;
      logic [IpWidth-1:0]   key_ip;
      logic                 key_ip_any;
      logic [PortWidth-1:0] key_port;
      logic                 key_port_any;
      logic [IpWidth-1:0]   target_ip;
      logic [PortWidth-1:0] target_port;
   } req_payload_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [IpWidth-1:0]     out_ip;
      logic [PortWidth-1:0]   out_port;
   } rsp_payload_type;

   // rule source: port_any in bit 49 down to ip in bits 31:0
   typedef struct packed {
      logic                 port_any;
      logic [PortWidth-1:0] port;
      logic                 ip_any;
      logic [IpWidth-1:0]   ip;
   } rule_key_type;

   typedef struct packed {
      logic [PortWidth-1:0] port;
      logic [IpWidth-1:0]   ip;
   } rule_target_type;

   localparam int KeyWidth    = $bits(rule_key_type);
   localparam int TargetWidth = $bits(rule_target_type);

   function automatic logic rule_hit(rule_key_type rule, logic [IpWidth-1:0] ip,
                                     logic [PortWidth-1:0] port);
      logic ip_ok;
      logic port_ok;
      ip_ok   = rule.ip_any || (rule.ip == ip);
      port_ok = rule.port_any || (rule.port == port);
      return ip_ok && port_ok;
   endfunction

endpackage

@@ design/nwrt_chan_if.sv @@
// ----------------------------------------------------------------------------
// nwrt_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface nwrt_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/nwrt_ram.sv @@
// ----------------------------------------------------------------------------
// nwrt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nwrt_ram #(
   parameter  int Width     = 8,
   parameter  int Depth     = 16,
   localparam int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/nwrt_engine.sv @@
// ----------------------------------------------------------------------------
// nwrt_engine
// Rule table control: appends rules, scans the stored rules in load order one
// entry per cycle and holds the response in an output register.
// ----------------------------------------------------------------------------
module nwrt_engine #(
   parameter  int RULES     = 64,
   localparam int AddrWidth = (RULES > 1) ? $clog2(RULES) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   nwrt_chan_if.sink                      req_chan,
   nwrt_chan_if.source                    rsp_chan,
   output logic                           mem_wr_en,
   output logic [AddrWidth-1:0]           mem_wr_addr,
   output nwrt_pkg::rule_key_type         key_wr_data,
   output nwrt_pkg::rule_target_type      tgt_wr_data,
   output logic                           mem_rd_en,
   output logic [AddrWidth-1:0]           mem_rd_addr,
   input  nwrt_pkg::rule_key_type         key_rd_data,
   input  nwrt_pkg::rule_target_type      tgt_rd_data
);
   import nwrt_pkg::*;

   localparam int CountWidth = $clog2(RULES + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] nxt_ff, nxt_in;
   logic                  last_ff, last_in;
   logic [IpWidth-1:0]    flow_ip_ff, flow_ip_in;
   logic [PortWidth-1:0]  flow_port_ff, flow_port_in;
   rsp_payload_type       res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   req_payload_type       req;
   logic                  accept;
   logic                  out_free;

   assign req      = req_chan.payload;
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign mem_wr_addr = count_ff[AddrWidth-1:0];
   assign key_wr_data = '{port_any: req.key_port_any, port: req.key_port,
                          ip_any: req.key_ip_any, ip: req.key_ip};
   assign tgt_wr_data = '{port: req.target_port, ip: req.target_ip};
   assign mem_rd_addr = (state_ff == S_IDLE) ? '0 : nxt_ff[AddrWidth-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      nxt_in       = nxt_ff;
      last_in      = last_ff;
      flow_ip_in   = flow_ip_ff;
      flow_port_in = flow_port_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               flow_ip_in   = req.key_ip;
               flow_port_in = req.key_port;
               res_in       = '{status: ST_STORED, out_ip: '0, out_port: '0};
               state_in     = S_DONE;
               if (req.action == ACT_LOAD) begin
                  if (req.key_ip_any && req.key_port_any) begin
                     res_in.status = ST_BADWILD;
                  end else if (count_ff >= CountWidth'(RULES)) begin
                     res_in.status = ST_FULL;
                  end else begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + 1'b1;
                  end
               end else if (req.key_ip_any || req.key_port_any) begin
                  res_in.status = ST_BADWILD;
               end else if (count_ff == '0) begin
                  res_in.status = ST_NOMATCH;
               end else begin
                  mem_rd_en = 1'b1;
                  nxt_in    = CountWidth'(1);
                  last_in   = (count_ff == CountWidth'(1));
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rule_hit(key_rd_data, flow_ip_ff, flow_port_ff)) begin
               res_in   = '{status: ST_MATCH, out_ip: tgt_rd_data.ip,
                            out_port: tgt_rd_data.port};
               state_in = S_DONE;
            end else if (last_ff) begin
               res_in   = '{status: ST_NOMATCH, out_ip: '0, out_port: '0};
               state_in = S_DONE;
            end else begin
               mem_rd_en = 1'b1;
               nxt_in    = nxt_ff + 1'b1;
               last_in   = (CountWidth'(nxt_ff + 1'b1) == count_ff);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nxt_ff       <= nxt_in;
      last_ff      <= last_in;
      flow_ip_ff   <= flow_ip_in;
      flow_port_ff <= flow_port_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

@@ design/nat_wildcard_rule_table_top.sv @@
// ----------------------------------------------------------------------------
// A load or a rejected item goes to the done state on transfer; the response is
// registered from there once the output register is free. A lookup first scans
// the stored rules up to the first matching rule, or through all of them when
// none matches; one rule RAM read a cycle. One item is handled at a time.
// Reset clears the rule count and the response; rule RAM contents are kept.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// nat_wildcard_rule_table_top
// NAT rule table with exact or wildcard source address and port per rule;
// earliest loaded matching rule wins.
// ----------------------------------------------------------------------------
module nat_wildcard_rule_table_top #(
   parameter int RULES = 64
) (
   input logic         clock,
   input logic         reset,
   nwrt_chan_if.sink   req_chan,
   nwrt_chan_if.source rsp_chan
);
   import nwrt_pkg::*;

   localparam int AddrWidth = (RULES > 1) ? $clog2(RULES) : 1;

   logic                 mem_wr_en;
   logic [AddrWidth-1:0] mem_wr_addr;
   rule_key_type         key_wr_data;
   rule_target_type      tgt_wr_data;
   logic                 mem_rd_en;
   logic [AddrWidth-1:0] mem_rd_addr;
   rule_key_type         key_rd_data;
   rule_target_type      tgt_rd_data;

   nwrt_engine #(
      .RULES (RULES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .key_wr_data (key_wr_data),
      .tgt_wr_data (tgt_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .key_rd_data (key_rd_data),
      .tgt_rd_data (tgt_rd_data)
   );

   nwrt_ram #(
      .Width (KeyWidth),
      .Depth (RULES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (key_rd_data)
   );

   nwrt_ram #(
      .Width (TargetWidth),
      .Depth (RULES)
   ) u_target_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (tgt_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (tgt_rd_data)
   );

endmodule
